// ----- rtl/dq_pkg.sv -----
`timescale 1ns / 1ps
// Deque package: sizes, payload types, command and status codes, ring index helpers.
// No dependencies; used by the interfaces, dq_ram and double_ended_queue_top.
package dq_pkg;

   localparam int DEPTH    = 64;
   localparam int ITEM_W   = 8;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int STATUS_W = 2;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [ITEM_W-1:0] item_type;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_REAR  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

   typedef struct packed {
      logic     en;
      logic     we;
      idx_type  addr;
      item_type wdata;
   } ram_req_type;

   function automatic idx_type idx_next(idx_type i);
      return (i == idx_type'(DEPTH - 1)) ? '0 : i + idx_type'(1);
   endfunction

   function automatic idx_type idx_prev(idx_type i);
      return (i == '0) ? idx_type'(DEPTH - 1) : i - idx_type'(1);
   endfunction

endpackage

// ----- rtl/dq_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the deque: command words in, result words out.
// Depends on dq_pkg.
interface dq_req_if;
   logic             valid;
   logic             ready;
   dq_pkg::cmd_type  cmd;
   dq_pkg::item_type push_item;

   modport source (output valid, output cmd, output push_item, input ready);
   modport sink   (input valid, input cmd, input push_item, output ready);
endinterface

interface dq_rsp_if;
   logic               valid;
   logic               ready;
   dq_pkg::item_type   popped_item;
   dq_pkg::status_type status;
   dq_pkg::item_type   front_item;
   dq_pkg::item_type   rear_item;
   dq_pkg::cnt_type    item_count;
   logic               is_empty;

   modport source (output valid, output popped_item, output status, output front_item,
                   output rear_item, output item_count, output is_empty, input ready);
   modport sink   (input valid, input popped_item, input status, input front_item,
                   input rear_item, input item_count, input is_empty, output ready);
endinterface

// ----- rtl/dq_ram.sv -----
`timescale 1ns / 1ps
// Single-port slot memory of the deque ring, one access per cycle, registered read.
// Depends on dq_pkg.
module dq_ram (
   input  logic                 clock,
   input  dq_pkg::ram_req_type  ram_req,
   output dq_pkg::item_type     rd_data
);
   import dq_pkg::*;

   item_type mem [DEPTH];
   item_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.en) begin
         if (ram_req.we) begin
            mem[ram_req.addr] <= ram_req.wdata;
         end else begin
            rd_data_ff <= mem[ram_req.addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/double_ended_queue_top.sv -----
`timescale 1ns / 1ps
// Deque top level: ring pointers, end-item cache, control and result register.
// Depends on dq_pkg, dq_if (dq_req_if, dq_rsp_if) and dq_ram.
//
//   channel    dir   word
//   req_chan   in    cmd, push_item
//   rsp_chan   out   popped_item, status, front_item, rear_item, item_count, is_empty
//
// Pushes, overflow, underflow and a pop that empties the deque write the result directly.
// A pop that leaves items: S_READ refills the new end item from the slot RAM read.
// One word in flight; the next is taken when idle and the result register is free
// or being drained in that cycle. A stalled result holds the input side.
// Reset clears pointers, count and handshake state; slot contents are not cleared.
module double_ended_queue_top (
   input logic      clock,
   input logic      reset,
   dq_req_if.sink   req_chan,
   dq_rsp_if.source rsp_chan
);
   import dq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   idx_type     head_ff, head_in, tail_ff, tail_in;
   cnt_type     count_ff, count_in;
   item_type    front_ff, front_in, rear_ff, rear_in, popped_ff, popped_in;
   logic        read_front_ff, read_front_in;

   logic        rsp_valid_ff, rsp_valid_in;
   item_type    out_popped_ff, out_popped_in;
   status_type  out_status_ff, out_status_in;
   item_type    out_front_ff, out_front_in;
   item_type    out_rear_ff, out_rear_in;
   cnt_type     out_count_ff, out_count_in;
   logic        out_empty_ff, out_empty_in;

   ram_req_type ram_req;
   item_type    ram_rdata;
   logic        rsp_free;
   logic        accept;
   logic        is_full;
   logic        is_zero;

   dq_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rdata)
   );

   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && rsp_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_full        = (count_ff == cnt_type'(DEPTH));
   assign is_zero        = (count_ff == '0);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      popped_in     = popped_ff;
      read_front_in = read_front_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_popped_in = out_popped_ff;
      out_status_in = out_status_ff;
      out_front_in  = out_front_ff;
      out_rear_in   = out_rear_ff;
      out_count_in  = out_count_ff;
      out_empty_in  = out_empty_ff;
      ram_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               out_popped_in = '0;
               out_status_in = ST_OK;
               out_front_in  = is_zero ? '0 : front_ff;
               out_rear_in   = is_zero ? '0 : rear_ff;
               out_count_in  = count_ff;
               out_empty_in  = is_zero;
               case (req_chan.cmd)
                  CMD_PUSH_FRONT: begin
                     if (is_full) begin
                        out_status_in = ST_OVER;
                     end else begin
                        head_in       = idx_prev(head_ff);
                        ram_req.en    = 1'b1;
                        ram_req.we    = 1'b1;
                        ram_req.addr  = head_in;
                        ram_req.wdata = req_chan.push_item;
                        front_in      = req_chan.push_item;
                        if (is_zero) begin
                           rear_in = req_chan.push_item;
                        end
                        count_in      = count_ff + cnt_type'(1);
                        out_front_in  = req_chan.push_item;
                        out_rear_in   = is_zero ? req_chan.push_item : rear_ff;
                        out_count_in  = count_in;
                        out_empty_in  = 1'b0;
                     end
                  end
                  CMD_PUSH_REAR: begin
                     if (is_full) begin
                        out_status_in = ST_OVER;
                     end else begin
                        tail_in       = idx_next(tail_ff);
                        ram_req.en    = 1'b1;
                        ram_req.we    = 1'b1;
                        ram_req.addr  = tail_ff;
                        ram_req.wdata = req_chan.push_item;
                        rear_in       = req_chan.push_item;
                        if (is_zero) begin
                           front_in = req_chan.push_item;
                        end
                        count_in      = count_ff + cnt_type'(1);
                        out_rear_in   = req_chan.push_item;
                        out_front_in  = is_zero ? req_chan.push_item : front_ff;
                        out_count_in  = count_in;
                        out_empty_in  = 1'b0;
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (is_zero) begin
                        out_status_in = ST_UNDER;
                     end else begin
                        head_in       = idx_next(head_ff);
                        count_in      = count_ff - cnt_type'(1);
                        out_popped_in = front_ff;
                        out_count_in  = count_in;
                        if (count_in == '0) begin
                           out_front_in = '0;
                           out_rear_in  = '0;
                           out_empty_in = 1'b1;
                        end else begin
                           rsp_valid_in  = 1'b0;
                           ram_req.en    = 1'b1;
                           ram_req.addr  = head_in;
                           popped_in     = front_ff;
                           read_front_in = 1'b1;
                           state_in      = S_READ;
                        end
                     end
                  end
                  CMD_POP_REAR: begin
                     if (is_zero) begin
                        out_status_in = ST_UNDER;
                     end else begin
                        tail_in       = idx_prev(tail_ff);
                        count_in      = count_ff - cnt_type'(1);
                        out_popped_in = rear_ff;
                        out_count_in  = count_in;
                        if (count_in == '0) begin
                           out_front_in = '0;
                           out_rear_in  = '0;
                           out_empty_in = 1'b1;
                        end else begin
                           rsp_valid_in  = 1'b0;
                           ram_req.en    = 1'b1;
                           ram_req.addr  = idx_prev(tail_in);
                           popped_in     = rear_ff;
                           read_front_in = 1'b0;
                           state_in      = S_READ;
                        end
                     end
                  end
                  default: begin
                     out_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_READ: begin
            // refill the cached end from the slot read, then show the word
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            out_popped_in = popped_ff;
            out_status_in = ST_OK;
            out_count_in  = count_ff;
            out_empty_in  = 1'b0;
            if (read_front_ff) begin
               front_in     = ram_rdata;
               out_front_in = ram_rdata;
               out_rear_in  = rear_ff;
            end else begin
               rear_in      = ram_rdata;
               out_rear_in  = ram_rdata;
               out_front_in = front_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      rear_ff       <= rear_in;
      popped_ff     <= popped_in;
      read_front_ff <= read_front_in;
      out_popped_ff <= out_popped_in;
      out_status_ff <= out_status_in;
      out_front_ff  <= out_front_in;
      out_rear_ff   <= out_rear_in;
      out_count_ff  <= out_count_in;
      out_empty_ff  <= out_empty_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.popped_item = out_popped_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.front_item  = out_front_ff;
   assign rsp_chan.rear_item   = out_rear_ff;
   assign rsp_chan.item_count  = out_count_ff;
   assign rsp_chan.is_empty    = out_empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(DEPTH))
      else $error("item count above depth");

   a_read_completes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("slot read did not produce a result word");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      accept && is_zero
      && (req_chan.cmd == CMD_POP_FRONT || req_chan.cmd == CMD_POP_REAR)
      |=> rsp_valid_ff && (out_status_ff == ST_UNDER))
      else $error("pop on empty deque not flagged");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_empty_ff
      |-> (out_front_ff == '0) && (out_rear_ff == '0) && (out_count_ff == '0))
      else $error("empty result carries stale ends");

endmodule

// ----- sim/double_ended_queue_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue_top: drives command words, predicts each
// result word with its own deque model and checks every field. Depends on dq_pkg and dq_if.
module double_ended_queue_top_tb;
   import dq_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SEG_WORDS   = 190;

   typedef struct packed {
      item_type   popped;
      status_type status;
      item_type   front;
      item_type   rear;
      cnt_type    count;
      logic       empty;
   } deque_view_type;

   logic clock;
   logic reset;
   bit   quiet;
   int   error_count;
   int   cycles;
   int   stall_left;

   item_type       ring [DEPTH];
   idx_type        head;
   idx_type        tail;
   cnt_type        fill;
   deque_view_type pending_views [$];

   dq_req_if req_chan ();
   dq_rsp_if rsp_chan ();

   double_ended_queue_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   function automatic deque_view_type apply_deque_op(cmd_type c, item_type d);
      deque_view_type v;
      v = '0;
      v.status = ST_OK;
      if (c == CMD_PUSH_FRONT || c == CMD_PUSH_REAR) begin
         if (fill == cnt_type'(DEPTH)) begin
            v.status = ST_OVER;
         end else if (c == CMD_PUSH_FRONT) begin
            head = idx_type'((int'(head) + DEPTH - 1) % DEPTH);
            ring[head] = d;
            fill = fill + 1'b1;
         end else begin
            ring[tail] = d;
            tail = idx_type'((int'(tail) + 1) % DEPTH);
            fill = fill + 1'b1;
         end
      end else begin
         if (fill == '0) begin
            v.status = ST_UNDER;
         end else if (c == CMD_POP_FRONT) begin
            v.popped = ring[head];
            head = idx_type'((int'(head) + 1) % DEPTH);
            fill = fill - 1'b1;
         end else begin
            tail = idx_type'((int'(tail) + DEPTH - 1) % DEPTH);
            v.popped = ring[tail];
            fill = fill - 1'b1;
         end
      end
      if (fill != '0) begin
         v.front = ring[head];
         v.rear  = ring[idx_type'((int'(tail) + DEPTH - 1) % DEPTH)];
      end
      v.count = fill;
      v.empty = (fill == '0);
      return v;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // result checker and predictor update
   always @(posedge clock) begin
      deque_view_type want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_views.size() == 0) begin
               $error("result word with no expectation waiting");
               error_count++;
            end else begin
               want = pending_views.pop_front();
               check_field("popped_item", want.popped, rsp_chan.popped_item);
               check_field("status", 8'(want.status), 8'(rsp_chan.status));
               check_field("front_item", want.front, rsp_chan.front_item);
               check_field("rear_item", want.rear, rsp_chan.rear_item);
               check_field("item_count", 8'(want.count), 8'(rsp_chan.item_count));
               check_field("is_empty", 8'(want.empty), 8'(rsp_chan.is_empty));
            end
         end
         if (req_chan.valid && req_chan.ready)
            pending_views.push_back(apply_deque_op(req_chan.cmd, req_chan.push_item));
      end
   end

   // result-side stalls in short bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** double_ended_queue_top: FAILED **");
         $finish;
      end
   end

   task automatic send_word(cmd_type c, item_type d);
      req_chan.valid     <= 1'b1;
      req_chan.cmd       <= c;
      req_chan.push_item <= d;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_views.size() != 0) @(posedge clock);
   endtask

   function automatic cmd_type any_push();
      return $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
   endfunction

   function automatic cmd_type any_pop();
      return $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
   endfunction

   task automatic test_empty_pops();
      send_word(CMD_POP_FRONT, item_type'($urandom_range(0, 255)));
      send_word(CMD_POP_REAR, item_type'($urandom_range(0, 255)));
   endtask

   task automatic test_both_ends();
      send_word(CMD_PUSH_FRONT, 8'h00);
      send_word(CMD_PUSH_REAR, 8'hFF);
      send_word(CMD_PUSH_FRONT, 8'h80);
      send_word(CMD_PUSH_REAR, 8'h01);
      send_word(CMD_POP_FRONT, 8'hFF);
      send_word(CMD_POP_REAR, 8'h00);
      send_word(CMD_PUSH_REAR, 8'h7F);
      send_word(CMD_POP_REAR, item_type'($urandom_range(0, 255)));
      send_word(CMD_POP_REAR, item_type'($urandom_range(0, 255)));
      send_word(CMD_POP_FRONT, item_type'($urandom_range(0, 255)));
      send_word(CMD_POP_FRONT, item_type'($urandom_range(0, 255)));
      // single item, then removed from the other end
      send_word(CMD_PUSH_FRONT, 8'h55);
      send_word(CMD_POP_REAR, 8'hAA);
   endtask

   // starts empty: fill past full, then drain past empty
   task automatic test_fill_overflow();
      for (int i = 0; i < DEPTH + 4; i++)
         send_word(any_push(), item_type'($urandom_range(0, 255)));
      for (int i = 0; i < DEPTH + 4; i++)
         send_word(any_pop(), item_type'($urandom_range(0, 255)));
   endtask

   task automatic test_random_mix(int push_pct, int words);
      for (int i = 0; i < words; i++) begin
         if ($urandom_range(0, 99) < push_pct)
            send_word(any_push(), item_type'($urandom_range(0, 255)));
         else
            send_word(any_pop(), item_type'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int push_mix [8];
      push_mix = '{85, 15, 50, 70, 30, 95, 5, 50};
      clock              = 1'b0;
      reset              = 1'b1;
      quiet              = 1'b0;
      error_count        = 0;
      cycles             = 0;
      stall_left         = 0;
      head               = '0;
      tail               = '0;
      fill               = '0;
      req_chan.valid     = 1'b0;
      req_chan.cmd       = CMD_PUSH_FRONT;
      req_chan.push_item = '0;
      rsp_chan.ready     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_pops();
      test_both_ends();
      wait_drain();
      test_fill_overflow();
      for (int s = 0; s < 8; s++) begin
         if (s == 7)
            quiet = 1'b1;
         test_random_mix(push_mix[s], SEG_WORDS);
      end

      wait_drain();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_views.size() == 0) begin
         $display("** double_ended_queue_top: PASSED **");
      end else begin
         $display("** double_ended_queue_top: FAILED **");
      end
      $finish;
   end

endmodule
